@@ src/ray_triangle_hit_test_macros.svh @@
// assertion helpers, clocked on aclk, disabled in reset
`ifndef RAY_TRIANGLE_HIT_TEST_MACROS_SVH
`define RAY_TRIANGLE_HIT_TEST_MACROS_SVH

`define RTH_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rth assertion failed");

`define RTH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rth assertion failed");

`endif

@@ src/rth_pkg.sv @@
package rth_pkg;

    localparam int COORD_W = 24;
    localparam int DIR_W   = 18;
    localparam int EPS_W   = 16;
    localparam int E_W     = COORD_W + 1;
    localparam int H_W     = DIR_W + E_W + 1;
    localparam int Q_W     = 2 * E_W + 1;
    localparam int PA_W    = E_W + H_W;
    localparam int PV_W    = DIR_W + Q_W;
    localparam int PT_W    = E_W + Q_W;
    localparam int A_W     = 71;
    localparam int T_W     = 78;
    localparam int EA_W    = EPS_W + 1 + A_W;
    localparam int CMP_W   = 104;
    localparam int NSTAGE  = 10;

    localparam int COORD_FRAC_BITS_DEF = 16;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DIR_X    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_DIR_Y    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_DIR_Z    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_EPSILON  = 3'd6;

    localparam logic signed [DIR_W-1:0] DIR_X_RESET = 18'sd65536;
    localparam logic [EPS_W-1:0]        EPS_RESET   = 16'd1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIR_W-1:0]   dir_t;
    typedef logic signed [E_W-1:0]     edge_t;
    typedef logic signed [H_W-1:0]     h_t;
    typedef logic signed [Q_W-1:0]     q_t;
    typedef logic signed [A_W-1:0]     acc_t;
    typedef logic signed [T_W-1:0]     tacc_t;

    typedef struct packed {
        logic st1;
        logic st2;
        logic st3;
    } front_en_t;

    typedef struct packed {
        logic st7;
        logic st8;
        logic st9;
        logic st10;
    } decide_en_t;

endpackage

@@ src/rth_mul.sv @@
module rth_mul #(
    parameter int AW = 25,
    parameter int BW = 44
) (
    input  logic                 aclk,
    input  logic                 en_a,
    input  logic                 en_b,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output logic signed [AW+BW-1:0] y
);
    localparam int LB = BW / 2;
    localparam int HB = BW - LB;
    localparam int LO_W = AW + LB + 1;
    localparam int HI_W = AW + HB;

    logic signed [AW+LB:0]    lo_reg, lo_next;
    logic signed [AW+HB-1:0]  hi_reg, hi_next;
    logic signed [AW+BW-1:0]  y_reg, y_next;

    always_comb begin
        lo_next = LO_W'(a) * LO_W'($signed({1'b0, b[LB-1:0]}));
        hi_next = HI_W'(a) * HI_W'($signed(b[BW-1:LB]));
        y_next  = $signed({hi_reg, {LB{1'b0}}})
                + $signed({{(HB-1){lo_reg[AW+LB]}}, lo_reg});
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
        if (en_b) begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;
endmodule

@@ src/rth_front.sv @@
module rth_front (
    input  logic               aclk,
    input  rth_pkg::front_en_t en,
    input  rth_pkg::coord_t    v0 [3],
    input  rth_pkg::coord_t    v1 [3],
    input  rth_pkg::coord_t    v2 [3],
    input  rth_pkg::coord_t    org [3],
    input  rth_pkg::dir_t      dir [3],
    output rth_pkg::edge_t     e1 [3],
    output rth_pkg::edge_t     e2 [3],
    output rth_pkg::edge_t     s [3],
    output rth_pkg::h_t        h [3],
    output rth_pkg::q_t        q [3]
);
    import rth_pkg::*;

    localparam int PH_W = DIR_W + E_W;
    localparam int PQ_W = 2 * E_W;

    edge_t e1_s1_reg [3], e2_s1_reg [3], s_s1_reg [3];
    edge_t e1_s2_reg [3], e2_s2_reg [3], s_s2_reg [3];
    edge_t e1_reg [3], e2_reg [3], s_reg [3];
    logic signed [DIR_W+E_W-1:0] ph_reg [6], ph_next [6];
    logic signed [2*E_W-1:0]     pq_reg [6], pq_next [6];
    h_t h_reg [3], h_next [3];
    q_t q_reg [3], q_next [3];

    always_comb begin
        ph_next[0] = PH_W'(dir[1]) * PH_W'(e2_s1_reg[2]);
        ph_next[1] = PH_W'(dir[2]) * PH_W'(e2_s1_reg[1]);
        ph_next[2] = PH_W'(dir[2]) * PH_W'(e2_s1_reg[0]);
        ph_next[3] = PH_W'(dir[0]) * PH_W'(e2_s1_reg[2]);
        ph_next[4] = PH_W'(dir[0]) * PH_W'(e2_s1_reg[1]);
        ph_next[5] = PH_W'(dir[1]) * PH_W'(e2_s1_reg[0]);
        pq_next[0] = PQ_W'(s_s1_reg[1]) * PQ_W'(e1_s1_reg[2]);
        pq_next[1] = PQ_W'(s_s1_reg[2]) * PQ_W'(e1_s1_reg[1]);
        pq_next[2] = PQ_W'(s_s1_reg[2]) * PQ_W'(e1_s1_reg[0]);
        pq_next[3] = PQ_W'(s_s1_reg[0]) * PQ_W'(e1_s1_reg[2]);
        pq_next[4] = PQ_W'(s_s1_reg[0]) * PQ_W'(e1_s1_reg[1]);
        pq_next[5] = PQ_W'(s_s1_reg[1]) * PQ_W'(e1_s1_reg[0]);
        for (int i = 0; i < 3; i++) begin
            h_next[i] = $signed({ph_reg[2*i][DIR_W+E_W-1], ph_reg[2*i]})
                      - $signed({ph_reg[2*i+1][DIR_W+E_W-1], ph_reg[2*i+1]});
            q_next[i] = $signed({pq_reg[2*i][2*E_W-1], pq_reg[2*i]})
                      - $signed({pq_reg[2*i+1][2*E_W-1], pq_reg[2*i+1]});
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            if (en.st1) begin
                e1_s1_reg[i] <= $signed({v1[i][COORD_W-1], v1[i]})
                              - $signed({v0[i][COORD_W-1], v0[i]});
                e2_s1_reg[i] <= $signed({v2[i][COORD_W-1], v2[i]})
                              - $signed({v0[i][COORD_W-1], v0[i]});
                s_s1_reg[i]  <= $signed({org[i][COORD_W-1], org[i]})
                              - $signed({v0[i][COORD_W-1], v0[i]});
            end
            if (en.st2) begin
                e1_s2_reg[i] <= e1_s1_reg[i];
                e2_s2_reg[i] <= e2_s1_reg[i];
                s_s2_reg[i]  <= s_s1_reg[i];
            end
            if (en.st3) begin
                e1_reg[i] <= e1_s2_reg[i];
                e2_reg[i] <= e2_s2_reg[i];
                s_reg[i]  <= s_s2_reg[i];
                h_reg[i]  <= h_next[i];
                q_reg[i]  <= q_next[i];
            end
        end
        if (en.st2) begin
            for (int k = 0; k < 6; k++) begin
                ph_reg[k] <= ph_next[k];
                pq_reg[k] <= pq_next[k];
            end
        end
    end

    assign e1 = e1_reg;
    assign e2 = e2_reg;
    assign s  = s_reg;
    assign h  = h_reg;
    assign q  = q_reg;
endmodule

@@ src/rth_decide.sv @@
module rth_decide #(
    parameter int COORD_FRAC_BITS = rth_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  rth_pkg::decide_en_t        en,
    input  logic [rth_pkg::EPS_W-1:0]  eps,
    input  rth_pkg::acc_t              a,
    input  rth_pkg::acc_t              u,
    input  rth_pkg::acc_t              v,
    input  rth_pkg::tacc_t             t,
    output logic                       hit
);
    import rth_pkg::*;

    localparam int SHIFT = 32 - COORD_FRAC_BITS;

    acc_t  a_f_reg, u_f_reg, v_f_reg;
    tacc_t t_f_reg, t_s8_reg, t_s9_reg;
    logic  bad_s8_reg, bad_s9_reg, hit_reg;
    logic  neg;
    logic  bad_next;
    logic [A_W-1:0]        thr;
    logic signed [A_W:0]   uv;
    logic signed [EA_W-1:0] ea;
    logic signed [CMP_W-1:0] ea_x, t_x;

    rth_mul #(.AW(EPS_W + 1), .BW(A_W)) u_eps_mul (
        .aclk (aclk),
        .en_a (en.st8),
        .en_b (en.st9),
        .a    ($signed({1'b0, eps})),
        .b    (a_f_reg),
        .y    (ea)
    );

    always_comb begin
        neg      = a[A_W-1];
        thr      = A_W'(eps) << (2 * COORD_FRAC_BITS);
        uv       = $signed({u_f_reg[A_W-1], u_f_reg}) + $signed({v_f_reg[A_W-1], v_f_reg});
        bad_next = (a_f_reg == '0) || (a_f_reg < $signed(thr))
                || u_f_reg[A_W-1] || (u_f_reg > a_f_reg)
                || v_f_reg[A_W-1] || (uv > $signed({a_f_reg[A_W-1], a_f_reg}));
        ea_x     = $signed({{(CMP_W-EA_W){ea[EA_W-1]}}, ea});
        t_x      = $signed({{(CMP_W-T_W){t_s9_reg[T_W-1]}}, t_s9_reg}) <<< SHIFT;
    end

    always_ff @(posedge aclk) begin
        if (en.st7) begin
            a_f_reg <= neg ? -a : a;
            u_f_reg <= neg ? -u : u;
            v_f_reg <= neg ? -v : v;
            t_f_reg <= neg ? -t : t;
        end
        if (en.st8) begin
            bad_s8_reg <= bad_next;
            t_s8_reg   <= t_f_reg;
        end
        if (en.st9) begin
            bad_s9_reg <= bad_s8_reg;
            t_s9_reg   <= t_s8_reg;
        end
        if (en.st10) begin
            hit_reg <= !bad_s9_reg && (ea_x < t_x);
        end
    end

    assign hit = hit_reg;
endmodule

@@ src/ray_triangle_hit_test.sv @@
// Ray/triangle hit test, fully pipelined.
// An input transfer reaches the result on m_tvalid through valid stages v_reg[1] to v_reg[NSTAGE].
// Throughput: one triangle per cycle; stages hold under back-pressure and
// bubbles are filled while the result waits.
// Reset: synchronous, active low; empties the pipeline and loads register defaults.
`include "ray_triangle_hit_test_macros.svh"

module ray_triangle_hit_test #(
    parameter int COORD_FRAC_BITS = rth_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [rth_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [rth_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z, vert2_x, vert2_y, vert2_z
    input  logic [215:0]                    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // hit, zero pad
    output logic [7:0]                      m_tdata
);
    import rth_pkg::*;

    coord_t org_reg [3];
    dir_t   dir_reg [3];
    logic [EPS_W-1:0] eps_reg;

    logic [NSTAGE:1]   v_reg;
    logic [NSTAGE+1:1] adv;

    coord_t v0 [3], v1 [3], v2 [3];
    edge_t  e1 [3], e2 [3], s [3];
    h_t     h [3];
    q_t     q [3];
    logic signed [PA_W-1:0] pa [3], pu [3];
    logic signed [PV_W-1:0] pv [3];
    logic signed [PT_W-1:0] pt [3];
    acc_t  a_reg, u_reg, v_sum_reg;
    tacc_t t_reg;
    logic  hit;
    front_en_t  fen;
    decide_en_t den;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            dir_reg[0] <= DIR_X_RESET;
            dir_reg[1] <= '0;
            dir_reg[2] <= '0;
            eps_reg    <= EPS_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_ORIGIN_X: org_reg[0] <= cfg_wdata[COORD_W-1:0];
                REG_ORIGIN_Y: org_reg[1] <= cfg_wdata[COORD_W-1:0];
                REG_ORIGIN_Z: org_reg[2] <= cfg_wdata[COORD_W-1:0];
                REG_DIR_X:    dir_reg[0] <= cfg_wdata[DIR_W-1:0];
                REG_DIR_Y:    dir_reg[1] <= cfg_wdata[DIR_W-1:0];
                REG_DIR_Z:    dir_reg[2] <= cfg_wdata[DIR_W-1:0];
                REG_EPSILON:  eps_reg    <= cfg_wdata[EPS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        adv[NSTAGE+1] = m_tready;
        for (int i = NSTAGE; i >= 1; i--) begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (adv[1]) begin
                v_reg[1] <= s_tvalid;
            end
            for (int i = 2; i <= NSTAGE; i++) begin
                if (adv[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign s_tready = adv[1];
    assign m_tvalid = v_reg[NSTAGE];
    assign m_tdata  = {7'd0, hit};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            v0[i] = s_tdata[COORD_W*i +: COORD_W];
            v1[i] = s_tdata[COORD_W*(i+3) +: COORD_W];
            v2[i] = s_tdata[COORD_W*(i+6) +: COORD_W];
        end
        fen.st1  = adv[1];
        fen.st2  = adv[2];
        fen.st3  = adv[3];
        den.st7  = adv[7];
        den.st8  = adv[8];
        den.st9  = adv[9];
        den.st10 = adv[10];
    end

    rth_front u_front (
        .aclk (aclk),
        .en   (fen),
        .v0   (v0),
        .v1   (v1),
        .v2   (v2),
        .org  (org_reg),
        .dir  (dir_reg),
        .e1   (e1),
        .e2   (e2),
        .s    (s),
        .h    (h),
        .q    (q)
    );

    for (genvar i = 0; i < 3; i++) begin : g_dot
        rth_mul #(.AW(E_W), .BW(H_W)) u_mul_a (
            .aclk (aclk), .en_a (adv[4]), .en_b (adv[5]),
            .a (e1[i]), .b (h[i]), .y (pa[i])
        );
        rth_mul #(.AW(E_W), .BW(H_W)) u_mul_u (
            .aclk (aclk), .en_a (adv[4]), .en_b (adv[5]),
            .a (s[i]), .b (h[i]), .y (pu[i])
        );
        rth_mul #(.AW(DIR_W), .BW(Q_W)) u_mul_v (
            .aclk (aclk), .en_a (adv[4]), .en_b (adv[5]),
            .a (dir_reg[i]), .b (q[i]), .y (pv[i])
        );
        rth_mul #(.AW(E_W), .BW(Q_W)) u_mul_t (
            .aclk (aclk), .en_a (adv[4]), .en_b (adv[5]),
            .a (e2[i]), .b (q[i]), .y (pt[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv[6]) begin
            a_reg     <= $signed({{(A_W-PA_W){pa[0][PA_W-1]}}, pa[0]})
                       + $signed({{(A_W-PA_W){pa[1][PA_W-1]}}, pa[1]})
                       + $signed({{(A_W-PA_W){pa[2][PA_W-1]}}, pa[2]});
            u_reg     <= $signed({{(A_W-PA_W){pu[0][PA_W-1]}}, pu[0]})
                       + $signed({{(A_W-PA_W){pu[1][PA_W-1]}}, pu[1]})
                       + $signed({{(A_W-PA_W){pu[2][PA_W-1]}}, pu[2]});
            v_sum_reg <= $signed({{(A_W-PV_W){pv[0][PV_W-1]}}, pv[0]})
                       + $signed({{(A_W-PV_W){pv[1][PV_W-1]}}, pv[1]})
                       + $signed({{(A_W-PV_W){pv[2][PV_W-1]}}, pv[2]});
            t_reg     <= $signed({{(T_W-PT_W){pt[0][PT_W-1]}}, pt[0]})
                       + $signed({{(T_W-PT_W){pt[1][PT_W-1]}}, pt[1]})
                       + $signed({{(T_W-PT_W){pt[2][PT_W-1]}}, pt[2]});
        end
    end

    rth_decide #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_decide (
        .aclk (aclk),
        .en   (den),
        .eps  (eps_reg),
        .a    (a_reg),
        .u    (u_reg),
        .v    (v_sum_reg),
        .t    (t_reg),
        .hit  (hit)
    );

    `RTH_ASSERT_NOW(a_empty_head_ready, aclk, aresetn, !v_reg[1], s_tready)
    `RTH_ASSERT_NEXT(a_transfer_enters, aclk, aresetn, s_tvalid && s_tready, v_reg[1])
    `RTH_ASSERT_NEXT(a_stall_keeps, aclk, aresetn, v_reg[NSTAGE-1] && !adv[NSTAGE-1], v_reg[NSTAGE-1])
endmodule
